// ===== design/cal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants for the cursor array list unit
// Field widths, command and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package cal_pkg;

   localparam int CMD_W   = 4;
   localparam int DATA_W  = 32;
   localparam int CNT_W   = 5;
   localparam int STAT_W  = 2;

   localparam int DEFAULT_DEPTH = 16;
   localparam int CNT_MAX       = (1 << CNT_W) - 1;

   localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 4'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND = 4'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 4'd3;
   localparam logic [CMD_W-1:0] CMD_START  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_END    = 4'd5;
   localparam logic [CMD_W-1:0] CMD_PREV   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_NEXT   = 4'd7;
   localparam logic [CMD_W-1:0] CMD_MOVE   = 4'd8;
   localparam logic [CMD_W-1:0] CMD_GET    = 4'd9;
   localparam logic [CMD_W-1:0] CMD_COUNT  = 4'd10;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOCUR = 2'd2;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic busy;
   } ctrl_stat_type;

endpackage
`default_nettype wire

// ===== design/cal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_ctrl: sequencer for the cursor array list unit
// Accepts an item, lets the datapath walk the store, then hands the result
// to the output register when it is free.
// ----------------------------------------------------------------------------
module cal_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output cal_pkg::ctrl_cmd_type  cmd,
   input  cal_pkg::ctrl_stat_type stat
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_WALK = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      finish;

   assign req_ready = (state_ff == S_IDLE);
   assign finish    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_WALK;
         end
         S_WALK: begin
            if (!stat.busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (finish) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = req_ready && req_valid;
   assign cmd.step   = (state_ff == S_WALK);
   assign cmd.finish = finish;

endmodule
`default_nettype wire

// ===== design/cal_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cal_dpath: store, length, cursor and walk logic of the cursor array list
// One store read and one store write per cycle; reads are registered and
// consumed in the next cycle, so a shift moves one entry per cycle.
// ----------------------------------------------------------------------------
module cal_dpath #(
   parameter int DEPTH = cal_pkg::DEFAULT_DEPTH
) (
   input  wire                             clock,
   input  wire                             reset,
   input  cal_pkg::ctrl_cmd_type           cmd,
   output cal_pkg::ctrl_stat_type          stat,
   input  wire                             csr_write_enable,
   input  wire        [cal_pkg::CNT_W-1:0] csr_write_data,
   input  wire        [cal_pkg::CMD_W-1:0] req_cmd,
   input  wire signed [cal_pkg::DATA_W-1:0] req_value,
   input  wire        [cal_pkg::CNT_W-1:0] req_position,
   output logic signed [cal_pkg::DATA_W-1:0] rsp_data,
   output logic       [cal_pkg::CNT_W-1:0] rsp_length,
   output logic       [cal_pkg::CNT_W-1:0] rsp_cursor,
   output logic       [cal_pkg::STAT_W-1:0] rsp_status
);

   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = cal_pkg::CNT_W;
   localparam int PW        = (AW > CW) ? AW : CW;
   localparam int DEPTH_LIM = (DEPTH > cal_pkg::CNT_MAX) ? cal_pkg::CNT_MAX : DEPTH;
   localparam logic [CW-1:0] DEPTH_CAP = CW'(DEPTH_LIM);

   logic signed [cal_pkg::DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0] cap_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cursor_ff, cursor_in;

   logic [cal_pkg::CMD_W-1:0]          op_ff;
   logic signed [cal_pkg::DATA_W-1:0]  val_ff;
   logic [CW-1:0]                      pos_ff;
   logic [cal_pkg::STAT_W-1:0]         status_ff, status_in;
   logic signed [cal_pkg::DATA_W-1:0]  acc_ff, acc_in;

   logic [CW-1:0] left_ff, left_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          rv_ff, rv_in;
   logic [AW-1:0] raddr_ff;
   logic signed [cal_pkg::DATA_W-1:0] rdata_ff;

   logic signed [cal_pkg::DATA_W-1:0] rsp_data_ff;
   logic [CW-1:0]                     rsp_length_ff;
   logic [CW-1:0]                     rsp_cursor_ff;
   logic [cal_pkg::STAT_W-1:0]        rsp_status_ff;

   logic [CW-1:0] eff_cap;
   logic          full, nocur, bad_pos, ok;
   logic [PW-1:0] count_wide, cursor_wide;
   logic [AW-1:0] count_addr, cursor_addr;

   logic                              mem_we;
   logic [AW-1:0]                     mem_waddr;
   logic signed [cal_pkg::DATA_W-1:0] mem_wdata;

   assign eff_cap     = (cap_ff > DEPTH_CAP) ? DEPTH_CAP : cap_ff;
   assign full        = (count_ff >= eff_cap);
   assign nocur       = (cursor_ff >= count_ff);
   assign bad_pos     = (req_position > count_ff);
   assign count_wide  = PW'(count_ff);
   assign cursor_wide = PW'(cursor_ff);
   assign count_addr  = count_wide[AW-1:0];
   assign cursor_addr = cursor_wide[AW-1:0];
   assign ok          = (status_ff == cal_pkg::ST_OK);

   assign stat.busy = (left_ff != '0) || rv_ff;

   assign rsp_data   = rsp_data_ff;
   assign rsp_length = rsp_length_ff;
   assign rsp_cursor = rsp_cursor_ff;
   assign rsp_status = rsp_status_ff;

   // item setup and store walk
   always_comb begin
      status_in = status_ff;
      left_in   = left_ff;
      ptr_in    = ptr_ff;
      rv_in     = 1'b0;
      if (cmd.load) begin
         status_in = cal_pkg::ST_OK;
         left_in   = '0;
         ptr_in    = cursor_addr;
         case (req_cmd)
            cal_pkg::CMD_INSERT: begin
               if (full) begin
                  status_in = cal_pkg::ST_FULL;
               end else begin
                  left_in = count_ff - cursor_ff;
                  ptr_in  = count_addr - AW'(1);
               end
            end
            cal_pkg::CMD_APPEND: begin
               if (full) status_in = cal_pkg::ST_FULL;
            end
            cal_pkg::CMD_REMOVE: begin
               if (nocur) status_in = cal_pkg::ST_NOCUR;
               else left_in = count_ff - cursor_ff;
            end
            cal_pkg::CMD_GET: begin
               if (nocur) status_in = cal_pkg::ST_NOCUR;
               else left_in = CW'(1);
            end
            cal_pkg::CMD_MOVE: begin
               if (bad_pos) status_in = cal_pkg::ST_RANGE;
            end
            cal_pkg::CMD_COUNT: begin
               left_in = count_ff;
               ptr_in  = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.step && (left_ff != '0)) begin
         rv_in   = 1'b1;
         left_in = left_ff - CW'(1);
         if (op_ff == cal_pkg::CMD_INSERT) ptr_in = ptr_ff - AW'(1);
         else ptr_in = ptr_ff + AW'(1);
      end
   end

   // result accumulation from returning reads
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) begin
         acc_in = '0;
      end else if (rv_ff) begin
         case (op_ff)
            cal_pkg::CMD_REMOVE: begin
               if (raddr_ff == cursor_addr) acc_in = rdata_ff;
            end
            cal_pkg::CMD_GET: begin
               acc_in = rdata_ff;
            end
            cal_pkg::CMD_COUNT: begin
               if (rdata_ff == val_ff) acc_in = acc_ff + 32'sd1;
            end
            default: begin
            end
         endcase
      end
   end

   // store write port: shift moves during the walk, new entry at finish
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = raddr_ff + AW'(1);
      mem_wdata = rdata_ff;
      if (rv_ff) begin
         case (op_ff)
            cal_pkg::CMD_INSERT: begin
               mem_we = 1'b1;
            end
            cal_pkg::CMD_REMOVE: begin
               mem_waddr = raddr_ff - AW'(1);
               mem_we    = (raddr_ff != cursor_addr);
            end
            default: begin
            end
         endcase
      end else if (cmd.finish && ok) begin
         mem_wdata = val_ff;
         case (op_ff)
            cal_pkg::CMD_INSERT: begin
               mem_we    = 1'b1;
               mem_waddr = cursor_addr;
            end
            cal_pkg::CMD_APPEND: begin
               mem_we    = 1'b1;
               mem_waddr = count_addr;
            end
            default: begin
            end
         endcase
      end
   end

   // length and cursor after the item
   always_comb begin
      count_in  = count_ff;
      cursor_in = cursor_ff;
      if (ok) begin
         case (op_ff)
            cal_pkg::CMD_CLEAR: begin
               count_in  = '0;
               cursor_in = '0;
            end
            cal_pkg::CMD_INSERT, cal_pkg::CMD_APPEND: begin
               count_in = count_ff + CW'(1);
            end
            cal_pkg::CMD_REMOVE: begin
               count_in = count_ff - CW'(1);
            end
            cal_pkg::CMD_START: begin
               cursor_in = '0;
            end
            cal_pkg::CMD_END: begin
               cursor_in = count_ff;
            end
            cal_pkg::CMD_PREV: begin
               if (cursor_ff != '0) cursor_in = cursor_ff - CW'(1);
            end
            cal_pkg::CMD_NEXT: begin
               if (cursor_ff < count_ff) cursor_in = cursor_ff + CW'(1);
            end
            cal_pkg::CMD_MOVE: begin
               cursor_in = pos_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= cal_pkg::CAP_RESET;
         count_ff  <= '0;
         cursor_ff <= '0;
         left_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (cmd.finish) begin
            count_ff  <= count_in;
            cursor_ff <= cursor_in;
         end
         left_ff <= left_in;
         rv_ff   <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_cmd;
         val_ff <= req_value;
         pos_ff <= req_position;
      end
      status_ff <= status_in;
      acc_ff    <= acc_in;
      ptr_ff    <= ptr_in;
      raddr_ff  <= ptr_ff;
      if (cmd.finish) begin
         rsp_data_ff   <= acc_ff;
         rsp_length_ff <= count_in;
         rsp_cursor_ff <= cursor_in;
         rsp_status_ff <= status_ff;
      end
   end

endmodule
`default_nettype wire

// ===== design/cursor_array_list_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cursor_array_list_unit: ordered word list with a cursor
// Clear, insert, append, remove, cursor moves, get and count over a store
// of DEPTH signed words.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  req     | req_valid / req_ready  | req_cmd, req_value, req_position
//  rsp     | rsp_valid / rsp_ready  | rsp_data, rsp_length, rsp_cursor, rsp_status
//  csr     | csr_write_enable       | csr_write_data (capacity limit)
//
//  One item at a time. Insert, remove, count and get walk n entries through
//  the store read port: n is length minus cursor for insert and remove,
//  length for count, 1 for get.
//  A finished result waits in the output register; the next item is accepted
//  meanwhile and completes once that register is taken.
//  Synchronous reset; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module cursor_array_list_unit #(
   parameter int DEPTH = cal_pkg::DEFAULT_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire        [cal_pkg::CMD_W-1:0]   req_cmd,
   input  wire signed [cal_pkg::DATA_W-1:0]  req_value,
   input  wire        [cal_pkg::CNT_W-1:0]   req_position,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic signed [cal_pkg::DATA_W-1:0] rsp_data,
   output logic       [cal_pkg::CNT_W-1:0]   rsp_length,
   output logic       [cal_pkg::CNT_W-1:0]   rsp_cursor,
   output logic       [cal_pkg::STAT_W-1:0]  rsp_status,
   input  wire                               csr_write_enable,
   input  wire        [cal_pkg::CNT_W-1:0]   csr_write_data
);

   cal_pkg::ctrl_cmd_type  cmd;
   cal_pkg::ctrl_stat_type stat;

   cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   cal_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_data         (rsp_data),
      .rsp_length       (rsp_length),
      .rsp_cursor       (rsp_cursor),
      .rsp_status       (rsp_status)
   );

endmodule
`default_nettype wire

// ===== sim/list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker: result predictor and scoreboard for the cursor array list
// Tracks the list contents, length, cursor and capacity limit from accepted
// commands and register writes, and checks every accepted result against the
// oldest expected one.
// ----------------------------------------------------------------------------
module list_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   input  wire                               req_ready,
   input  wire        [cal_pkg::CMD_W-1:0]   req_cmd,
   input  wire signed [cal_pkg::DATA_W-1:0]  req_value,
   input  wire        [cal_pkg::CNT_W-1:0]   req_position,
   input  wire                               rsp_valid,
   input  wire                               rsp_ready,
   input  wire signed [cal_pkg::DATA_W-1:0]  rsp_data,
   input  wire        [cal_pkg::CNT_W-1:0]   rsp_length,
   input  wire        [cal_pkg::CNT_W-1:0]   rsp_cursor,
   input  wire        [cal_pkg::STAT_W-1:0]  rsp_status,
   input  wire                               csr_write_enable,
   input  wire        [cal_pkg::CNT_W-1:0]   csr_write_data,
   output int                                fault_count,
   output int                                outstanding
);
   import cal_pkg::*;

   localparam int LIST_DEPTH = DEFAULT_DEPTH;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [CNT_W-1:0]         length;
      logic [CNT_W-1:0]         cursor;
      logic [STAT_W-1:0]        status;
   } list_result_type;

   logic signed [DATA_W-1:0] words [LIST_DEPTH];
   logic [CNT_W-1:0]         word_count;
   logic [CNT_W-1:0]         cursor_pos;
   logic [CNT_W-1:0]         capacity;
   list_result_type          expected_q [$];

   function automatic list_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic signed [DATA_W-1:0] value,
                                                     input logic [CNT_W-1:0] position);
      list_result_type res;
      int              limit;
      int              i;
      res = '0;
      res.status = ST_OK;
      limit = (int'(capacity) > LIST_DEPTH) ? LIST_DEPTH : int'(capacity);
      case (cmd)
         CMD_CLEAR: begin
            word_count = '0;
            cursor_pos = '0;
         end
         CMD_INSERT: begin
            if (int'(word_count) >= limit) begin
               res.status = ST_FULL;
            end else begin
               for (i = int'(word_count); i > int'(cursor_pos); i--)
                  words[i] = words[i-1];
               words[cursor_pos] = value;
               word_count = word_count + 1'b1;
            end
         end
         CMD_APPEND: begin
            if (int'(word_count) >= limit) begin
               res.status = ST_FULL;
            end else begin
               words[word_count] = value;
               word_count = word_count + 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (cursor_pos >= word_count) begin
               res.status = ST_NOCUR;
            end else begin
               res.data = words[cursor_pos];
               for (i = int'(cursor_pos); i + 1 < int'(word_count); i++)
                  words[i] = words[i+1];
               word_count = word_count - 1'b1;
            end
         end
         CMD_START: cursor_pos = '0;
         CMD_END:   cursor_pos = word_count;
         CMD_PREV: begin
            if (cursor_pos != '0)
               cursor_pos = cursor_pos - 1'b1;
         end
         CMD_NEXT: begin
            if (cursor_pos < word_count)
               cursor_pos = cursor_pos + 1'b1;
         end
         CMD_MOVE: begin
            if (position > word_count)
               res.status = ST_RANGE;
            else
               cursor_pos = position;
         end
         CMD_GET: begin
            if (cursor_pos >= word_count)
               res.status = ST_NOCUR;
            else
               res.data = words[cursor_pos];
         end
         CMD_COUNT: begin
            for (i = 0; i < int'(word_count); i++)
               if (words[i] == value)
                  res.data = res.data + 1;
         end
         default: ;
      endcase
      res.length = word_count;
      res.cursor = cursor_pos;
      return res;
   endfunction

   task automatic note_fault(input string msg);
      if (fault_count < 10)
         $display("%0t ns: %s", $time, msg);
      fault_count++;
   endtask

   always @(posedge clock) begin : watch
      list_result_type want;
      if (reset) begin
         word_count = '0;
         cursor_pos = '0;
         capacity = CAP_RESET;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               note_fault($sformatf("unexpected item: data %0d length %0d cursor %0d status %0d",
                                    rsp_data, rsp_length, rsp_cursor, rsp_status));
            end else begin
               want = expected_q.pop_front();
               if (rsp_data !== want.data || rsp_length !== want.length ||
                   rsp_cursor !== want.cursor || rsp_status !== want.status)
                  note_fault($sformatf({"bad item: expected data %0d length %0d cursor %0d ",
                                        "status %0d, got data %0d length %0d cursor %0d ",
                                        "status %0d"},
                                       want.data, want.length, want.cursor, want.status,
                                       rsp_data, rsp_length, rsp_cursor, rsp_status));
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(apply_command(req_cmd, req_value, req_position));
         if (csr_write_enable)
            capacity = csr_write_data;
      end
      outstanding <= expected_q.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for cursor_array_list_unit
// Directed corner commands, then bursts of random list traffic under a range
// of capacity limits, with random idling on both channels and one long
// result stall. Checking is done by list_checker.
// ----------------------------------------------------------------------------
module tb;
   import cal_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASE_ITEMS = 200;
   localparam int PHASES      = 8;
   localparam int LONG_HOLD   = 100;
   localparam int HOLD_AT     = 300;

   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd11;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

   typedef enum logic [1:0] {BURST_FILL, BURST_WALK, BURST_DRAIN, BURST_NOISE} burst_kind_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd;
   logic signed [DATA_W-1:0] req_value;
   logic [CNT_W-1:0]         req_position;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic signed [DATA_W-1:0] rsp_data;
   logic [CNT_W-1:0]         rsp_length;
   logic [CNT_W-1:0]         rsp_cursor;
   logic [STAT_W-1:0]        rsp_status;
   logic                     csr_write_enable;
   logic [CNT_W-1:0]         csr_write_data;
   int                       fault_count;
   int                       outstanding;
   bit                       sender_eager;
   logic [CNT_W-1:0]         phase_caps [PHASES];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cursor_array_list_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_length       (rsp_length),
      .rsp_cursor       (rsp_cursor),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   list_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_value        (req_value),
      .req_position     (req_position),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .rsp_length       (rsp_length),
      .rsp_cursor       (rsp_cursor),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fault_count      (fault_count),
      .outstanding      (outstanding)
   );

   task automatic send_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [DATA_W-1:0] value,
                            input logic [CNT_W-1:0] position);
      int gap;
      gap = sender_eager ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_capacity(input logic [CNT_W-1:0] limit);
      wait_for_results();
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // small pool of repeats so that count finds matches
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFFFFFF;
         1:       return 32'sh80000000;
         2:       return -32'sd1;
         3, 4:    return $urandom_range(0, 3);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_position();
      if ($urandom_range(0, 3) == 0)
         return CNT_W'($urandom_range(0, 31));
      return CNT_W'($urandom_range(0, 16));
   endfunction

   function automatic logic [CMD_W-1:0] pick_command(input burst_kind_type kind);
      int r;
      r = $urandom_range(0, 99);
      case (kind)
         BURST_FILL: begin
            if (r < 45) return CMD_INSERT;
            if (r < 85) return CMD_APPEND;
            if (r < 90) return CMD_NEXT;
            if (r < 95) return CMD_PREV;
            return CMD_COUNT;
         end
         BURST_WALK: begin
            if (r < 15) return CMD_START;
            if (r < 20) return CMD_END;
            if (r < 40) return CMD_NEXT;
            if (r < 50) return CMD_PREV;
            if (r < 60) return CMD_MOVE;
            if (r < 85) return CMD_GET;
            return CMD_COUNT;
         end
         BURST_DRAIN: begin
            if (r < 50) return CMD_REMOVE;
            if (r < 60) return CMD_START;
            if (r < 70) return CMD_MOVE;
            if (r < 80) return CMD_PREV;
            if (r < 90) return CMD_GET;
            return CMD_APPEND;
         end
         default: return CMD_W'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin : stimulus
      int             p;
      int             sent;
      int             burst_len;
      int             r;
      burst_kind_type kind;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= CMD_CLEAR;
      req_value        <= '0;
      req_position     <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      sender_eager = 1'b0;
      phase_caps = '{5'd31, 5'd1, 5'd0, 5'd8, 5'd16, 5'd0, 5'd17, 5'd3};
      phase_caps[5] = CNT_W'($urandom_range(0, 31));
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list corners, boundary words, cursor edges, spare codes
      send_item(CMD_GET,      '0,            '0);
      send_item(CMD_REMOVE,   '0,            '0);
      send_item(CMD_PREV,     '0,            '0);
      send_item(CMD_NEXT,     '0,            '0);
      send_item(CMD_MOVE,     '0,            5'd1);
      send_item(CMD_MOVE,     '0,            5'd31);
      send_item(CMD_APPEND,   32'sh7FFFFFFF, '0);
      send_item(CMD_APPEND,   32'sh80000000, '0);
      send_item(CMD_INSERT,   -32'sd1,       '0);
      send_item(CMD_INSERT,   '0,            '0);
      send_item(CMD_COUNT,    -32'sd1,       '0);
      send_item(CMD_COUNT,    32'sh80000000, '0);
      send_item(CMD_END,      '0,            '0);
      send_item(CMD_NEXT,     '0,            '0);
      send_item(CMD_GET,      '0,            '0);
      send_item(CMD_MOVE,     '0,            5'd4);
      send_item(CMD_MOVE,     '0,            5'd0);
      send_item(CMD_GET,      '0,            '0);
      send_item(CMD_NEXT,     '0,            '0);
      send_item(CMD_REMOVE,   '0,            '0);
      send_item(CMD_COUNT,    '0,            '0);
      send_item(CMD_SPARE_HI, -32'sd1,       5'd31);
      send_item(CMD_SPARE_LO, 32'sd5,        5'd2);
      send_item(CMD_CLEAR,    '0,            '0);
      send_item(CMD_COUNT,    '0,            '0);

      for (p = 0; p < PHASES; p++) begin
         write_capacity(phase_caps[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r < 4)
               kind = BURST_FILL;
            else if (r < 6)
               kind = BURST_WALK;
            else if (r < 8)
               kind = BURST_DRAIN;
            else
               kind = BURST_NOISE;
            burst_len = $urandom_range(3, 12);
            sender_eager = ($urandom_range(0, 3) == 0);
            repeat (burst_len) begin
               send_item(pick_command(kind), pick_value(), pick_position());
               sent++;
            end
         end
      end

      wait_for_results();
      repeat (40) @(posedge clock);
      if (fault_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : result_side
      int taken;
      int gap;
      bit eager;
      taken = 0;
      eager = 1'b0;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (taken % 40 == 0)
            eager = ($urandom_range(0, 2) == 0);
         if (taken == HOLD_AT)
            gap = LONG_HOLD;
         else
            gap = eager ? 0 : $urandom_range(0, 5);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         taken++;
      end
   end

   initial begin : watchdog
      int idle;
      idle = 0;
      wait (reset === 1'b0);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
            idle = 0;
         else
            idle++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
